FILE: design/napt_pkg.sv
`timescale 1ns / 1ps

package napt_pkg;

    localparam int unsigned DefTableEntries = 16;
    localparam logic [15:0] PortBase = 16'd49152;
    localparam logic [7:0]  ProtoTcp  = 8'd6;
    localparam logic [7:0]  ProtoUdp  = 8'd17;
    localparam logic [7:0]  ProtoIcmp = 8'd1;
    localparam logic [7:0]  IcmpEchoReq = 8'd8;
    localparam logic [7:0]  IcmpEchoRep = 8'd0;

    localparam logic [1:0] ActPass = 2'd0;
    localparam logic [1:0] ActRewrite = 2'd1;
    localparam logic [1:0] ActFull = 2'd2;

    localparam logic [2:0] CfgNatEnable = 3'd0;
    localparam logic [2:0] CfgMasqIp = 3'd1;
    localparam logic [2:0] CfgNetmask = 3'd2;
    localparam logic [2:0] CfgTcpTo = 3'd3;
    localparam logic [2:0] CfgUdpTo = 3'd4;
    localparam logic [2:0] CfgIcmpTo = 3'd5;

    typedef struct packed {
        logic        operation;
        logic [7:0]  protocol;
        logic [7:0]  icmp_type;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_checksum;
        logic [15:0] l4_checksum;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_src_ip;
        logic [31:0] out_dst_ip;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [15:0] out_ip_checksum;
        logic [15:0] out_l4_checksum;
    } t_out;

    // lookup key broadcast to every cell
    typedef struct packed {
        logic        inbound;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] peer_port;
        logic [15:0] map_key;
        logic [31:0] now;
        logic [30:0] tcp_to;
        logic [30:0] udp_to;
        logic [30:0] icmp_to;
    } t_query;

    // handed from cell to cell: first hit / first free and hit payload
    typedef struct packed {
        logic        hit_seen;
        logic        free_seen;
        logic [31:0] cip;
        logic [15:0] cport;
        logic [15:0] mport;
    } t_chain;

    typedef struct packed {
        logic        touch;
        logic        alloc;
        logic [15:0] port;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_CMP, S_SEL, S_C1, S_C2, S_C3
    } t_state;

    function automatic logic [15:0] csum16(input logic [15:0] hc, input logic [15:0] oldw,
                                           input logic [15:0] neww);
        logic [17:0] c;
        logic [16:0] f1;
        logic [16:0] f2;
        c  = {2'b00, ~hc} + {2'b00, ~oldw} + {2'b00, neww};
        f1 = {1'b0, c[15:0]} + {15'd0, c[17:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return ~f2[15:0];
    endfunction

endpackage

FILE: design/napt_cell.sv
`timescale 1ns / 1ps

module napt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_eval,
    input  napt_pkg::t_query i_q,
    input  napt_pkg::t_cmd  i_cmd,
    input  napt_pkg::t_chain i_chain,
    output napt_pkg::t_chain o_chain
);
    import napt_pkg::*;

    logic        r_valid;
    logic [7:0]  r_proto;
    logic [31:0] r_cip;
    logic [31:0] r_pip;
    logic [15:0] r_cport;
    logic [15:0] r_pport;
    logic [15:0] r_mport;
    logic [31:0] r_seen;
    logic        r_hit;
    logic        r_free;

    logic        w_mout;
    logic        w_min;
    logic [31:0] w_age;
    logic [30:0] w_ttl;
    logic        w_exp;
    logic        w_first_hit;
    logic        w_first_free;

    // local compare against the broadcast key
    always_comb begin
        w_mout = r_valid && r_proto == i_q.proto && r_cip == i_q.sip && r_pip == i_q.dip
                 && r_cport == i_q.sport && r_pport == i_q.peer_port;
        w_min  = r_valid && r_proto == i_q.proto && r_mport == i_q.map_key
                 && r_pip == i_q.sip;
        w_age  = i_q.now - r_seen;
        w_ttl  = (r_proto == ProtoTcp) ? i_q.tcp_to :
                 (r_proto == ProtoUdp) ? i_q.udp_to : i_q.icmp_to;
        w_exp  = !w_age[31] && (w_age[30:0] > w_ttl);
    end

    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_hit  <= i_q.inbound ? w_min : w_mout;
            r_free <= !r_valid || w_exp;
        end
    end

    // priority handoff: first cell with a flag claims it
    always_comb begin
        w_first_hit  = r_hit && !i_chain.hit_seen;
        w_first_free = r_free && !i_chain.free_seen;
        o_chain.hit_seen  = i_chain.hit_seen || r_hit;
        o_chain.free_seen = i_chain.free_seen || r_free;
        o_chain.cip   = w_first_hit ? r_cip : i_chain.cip;
        o_chain.cport = w_first_hit ? r_cport : i_chain.cport;
        o_chain.mport = w_first_hit ? r_mport : i_chain.mport;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.alloc && w_first_free) begin
            r_valid <= 1'b1;
        end
    end

    // entry update
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc && w_first_free) begin
            r_proto <= i_q.proto;
            r_cip   <= i_q.sip;
            r_pip   <= i_q.dip;
            r_cport <= i_q.sport;
            r_pport <= i_q.peer_port;
            r_mport <= i_cmd.port;
            r_seen  <= i_q.now;
        end else if (i_cmd.touch && w_first_hit) begin
            r_seen  <= i_q.now;
        end
    end

endmodule

FILE: design/napt_header_rewriter.sv
`timescale 1ns / 1ps

// Each input beat is captured, then passes compare, select and three checksum steps
// to the result beat; one header in flight, so no new header is taken until the last leaves S_C3.
// Lookup runs in parallel across TABLE_ENTRIES cells; first match and first free
// entry are picked along the cell chain in the select cycle.
// Reset (i_rst_n low, synchronous): all entries invalid, next port 49152,
// registers to their defaults, no result pending.
module napt_header_rewriter #(
    parameter int unsigned TABLE_ENTRIES = napt_pkg::DefTableEntries
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  napt_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output napt_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import napt_pkg::*;

    t_state      r_state, n_state;
    t_in         r_in;
    t_query      r_q;
    logic        r_elig;
    logic [1:0]  r_act;
    logic [31:0] r_cip;
    logic [15:0] r_cport;
    logic [15:0] r_mport;
    logic [15:0] r_ipc;
    logic [15:0] r_l4;
    logic [15:0] r_port_pool;
    t_out        r_out;
    logic        r_out_valid;

    logic        r_en;
    logic [31:0] r_masq;
    logic [31:0] r_mask;
    logic [30:0] r_tcp_to;
    logic [30:0] r_udp_to;
    logic [30:0] r_icmp_to;

    t_chain      w_chain [0:TABLE_ENTRIES];
    t_cmd        w_cmd;
    logic        w_eval;
    logic        w_accept;
    logic        w_icmp;
    logic        w_ok_out;
    logic        w_ok_in;
    logic        w_elig;
    logic [31:0] w_old_ip;
    logic [31:0] w_new_ip;
    logic [15:0] w_old_port;
    logic [15:0] w_new_port;
    logic        r_icmp;
    logic        w_done;
    t_out        w_res;
    logic [15:0] w_l4_fin;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_masq    <= '0;
            r_mask    <= '0;
            r_tcp_to  <= 31'd300000;
            r_udp_to  <= 31'd60000;
            r_icmp_to <= 31'd30000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgNatEnable: r_en <= i_cfg_data[0];
                CfgMasqIp:    r_masq <= i_cfg_data;
                CfgNetmask:   r_mask <= i_cfg_data;
                CfgTcpTo:     r_tcp_to <= i_cfg_data[30:0];
                CfgUdpTo:     r_udp_to <= i_cfg_data[30:0];
                CfgIcmpTo:    r_icmp_to <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // packet filter
    always_comb begin
        w_icmp   = i_in.protocol == ProtoIcmp;
        w_ok_out = i_in.protocol == ProtoTcp || i_in.protocol == ProtoUdp
                   || (w_icmp && i_in.icmp_type == IcmpEchoReq);
        w_ok_in  = i_in.protocol == ProtoTcp || i_in.protocol == ProtoUdp
                   || (w_icmp && i_in.icmp_type == IcmpEchoRep);
        if (!i_in.operation) begin
            w_elig = r_en && w_ok_out && ((i_in.dst_ip & r_mask) == (r_masq & r_mask))
                     && i_in.dst_ip != r_masq;
        end else begin
            w_elig = r_en && w_ok_in && i_in.dst_ip == r_masq;
        end
    end

    // capture beat and key
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in    <= i_in;
            r_elig  <= w_elig;
            r_icmp  <= w_icmp;
            r_q.inbound   <= i_in.operation;
            r_q.proto     <= i_in.protocol;
            r_q.sip       <= i_in.src_ip;
            r_q.dip       <= i_in.dst_ip;
            r_q.sport     <= i_in.src_port;
            r_q.peer_port <= w_icmp ? 16'd0 : i_in.dst_port;
            r_q.map_key   <= w_icmp ? i_in.src_port : i_in.dst_port;
            r_q.now       <= i_in.now_ms;
            r_q.tcp_to    <= r_tcp_to;
            r_q.udp_to    <= r_udp_to;
            r_q.icmp_to   <= r_icmp_to;
        end
    end

    // cell chain
    assign w_chain[0] = '0;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        napt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_eval  (w_eval),
            .i_q     (r_q),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = S_C1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_C3;
            S_C3:   if (w_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // FSM outputs
    always_comb begin
        o_in_ready = r_state == S_IDLE;
        w_eval     = r_state == S_CMP;
        w_done     = !r_out_valid || i_out_ready;
        w_cmd.port = r_port_pool;
        w_cmd.touch = 1'b0;
        w_cmd.alloc = 1'b0;
        if (r_state == S_SEL && r_elig) begin
            w_cmd.touch = w_chain[TABLE_ENTRIES].hit_seen;
            w_cmd.alloc = !w_chain[TABLE_ENTRIES].hit_seen && !r_q.inbound
                          && w_chain[TABLE_ENTRIES].free_seen;
        end
    end

    // select result and advance port pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_pool <= PortBase;
        end else if (w_cmd.alloc) begin
            r_port_pool <= (r_port_pool == 16'hffff) ? PortBase : r_port_pool + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEL) begin
            r_cip   <= w_chain[TABLE_ENTRIES].cip;
            r_cport <= w_chain[TABLE_ENTRIES].cport;
            r_mport <= w_cmd.alloc ? r_port_pool : w_chain[TABLE_ENTRIES].mport;
            if (!r_elig) r_act <= ActPass;
            else if (w_cmd.touch || w_cmd.alloc) r_act <= ActRewrite;
            else if (!r_q.inbound) r_act <= ActFull;
            else r_act <= ActPass;
        end
    end

    // incremental checksum operands
    always_comb begin
        w_old_ip   = r_q.inbound ? r_in.dst_ip : r_in.src_ip;
        w_new_ip   = r_q.inbound ? r_cip : r_masq;
        w_old_port = (r_q.inbound && !r_icmp) ? r_in.dst_port : r_in.src_port;
        w_new_port = r_q.inbound ? r_cport : r_mport;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_C1: begin
                r_ipc <= csum16(r_in.ip_checksum, w_old_ip[31:16], w_new_ip[31:16]);
                r_l4  <= r_icmp ? csum16(r_in.l4_checksum, w_old_port, w_new_port)
                                : csum16(r_in.l4_checksum, w_old_ip[31:16], w_new_ip[31:16]);
            end
            S_C2: begin
                r_ipc <= csum16(r_ipc, w_old_ip[15:0], w_new_ip[15:0]);
                if (!r_icmp) r_l4 <= csum16(r_l4, w_old_ip[15:0], w_new_ip[15:0]);
            end
            default: ;
        endcase
    end

    // final result
    always_comb begin
        w_l4_fin = r_icmp ? r_l4 : csum16(r_l4, w_old_port, w_new_port);
        if (r_q.proto == ProtoUdp && w_l4_fin == 16'd0) w_l4_fin = 16'hffff;
        if (r_q.proto == ProtoUdp && r_in.l4_checksum == 16'd0) w_l4_fin = 16'd0;
        w_res.action          = r_act;
        w_res.out_src_ip      = r_in.src_ip;
        w_res.out_dst_ip      = r_in.dst_ip;
        w_res.out_src_port    = r_in.src_port;
        w_res.out_dst_port    = r_in.dst_port;
        w_res.out_ip_checksum = r_in.ip_checksum;
        w_res.out_l4_checksum = r_in.l4_checksum;
        if (r_act == ActRewrite) begin
            w_res.out_ip_checksum = r_ipc;
            w_res.out_l4_checksum = w_l4_fin;
            if (!r_q.inbound) begin
                w_res.out_src_ip   = r_masq;
                w_res.out_src_port = r_mport;
            end else begin
                w_res.out_dst_ip = r_cip;
                if (r_icmp) w_res.out_src_port = r_cport;
                else        w_res.out_dst_port = r_cport;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_C3 && w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_C3 && w_done) r_out <= w_res;
    end

endmodule

FILE: bench/napt_header_rewriter_test.sv
`timescale 1ns / 1ps

module napt_header_rewriter_test;
    import napt_pkg::*;

    localparam logic OpOut = 1'b0;
    localparam logic OpIn  = 1'b1;
    localparam int   NumEntries = DefTableEntries;
    localparam logic [31:0] MasqA = 32'hC0A8_0401;
    localparam logic [31:0] MaskA = 32'hFFFF_FF00;

    typedef enum logic {
        RowItem, RowCfg
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        t_in         pkt;
        bit          typed;
        t_out        want;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_in   i_in = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    napt_header_rewriter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the registers and of the translation table
    logic        cfg_en = 1'b0;
    logic [31:0] cfg_masq = '0;
    logic [31:0] cfg_mask = '0;
    logic [30:0] cfg_tcp_to = 31'd300000;
    logic [30:0] cfg_udp_to = 31'd60000;
    logic [30:0] cfg_icmp_to = 31'd30000;

    bit          tv [NumEntries];
    logic [7:0]  tproto [NumEntries];
    logic [31:0] tcip [NumEntries];
    logic [31:0] tpip [NumEntries];
    logic [15:0] tcport [NumEntries];
    logic [15:0] tpport [NumEntries];
    logic [15:0] tmport [NumEntries];
    logic [31:0] tlast [NumEntries];
    logic [15:0] port_pool = PortBase;

    t_out  rewrite_q [$];
    bit    cur_typed = 1'b0;
    t_out  cur_want = '0;
    int    errors = 0;
    int    n_items = 0, n_rewrite = 0, n_full = 0, n_pass = 0, n_cfg = 0;

    // stimulus knobs
    int    send_idle = 0;
    int    recv_stall = 0;
    int    tstep = 100;
    bit    hold_req = 1'b0;
    int    hold_cnt = 0;
    logic [31:0] now_t = '0;
    logic [31:0] clients [4];
    logic [31:0] peers [4];
    logic [15:0] cports [4];
    t_row  rows [$];

    initial begin
        for (int i = 0; i < NumEntries; i++) begin
            tv[i] = 1'b0; tproto[i] = '0; tcip[i] = '0; tpip[i] = '0;
            tcport[i] = '0; tpport[i] = '0; tmport[i] = '0; tlast[i] = '0;
        end
    end

    // RFC 1624 update of one 16-bit word
    function automatic logic [15:0] fold16(logic [15:0] hc, logic [15:0] ow, logic [15:0] nw);
        logic [17:0] s;
        s = {2'b00, ~hc} + {2'b00, ~ow} + {2'b00, nw};
        s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
        s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
        return ~s[15:0];
    endfunction

    function automatic logic [15:0] fold32(logic [15:0] hc, logic [31:0] ov, logic [31:0] nv);
        return fold16(fold16(hc, ov[31:16], nv[31:16]), ov[15:0], nv[15:0]);
    endfunction

    function automatic t_out passthru(t_in x, logic [1:0] act);
        t_out r;
        r.action = act;
        r.out_src_ip = x.src_ip;
        r.out_dst_ip = x.dst_ip;
        r.out_src_port = x.src_port;
        r.out_dst_port = x.dst_port;
        r.out_ip_checksum = x.ip_checksum;
        r.out_l4_checksum = x.l4_checksum;
        return r;
    endfunction

    function automatic bit aged(int i, logic [31:0] now);
        logic [30:0] ttl;
        logic [31:0] d;
        ttl = (tproto[i] == ProtoTcp) ? cfg_tcp_to :
              (tproto[i] == ProtoUdp) ? cfg_udp_to : cfg_icmp_to;
        d = now - tlast[i];
        return (d < 32'h8000_0000) && (d > {1'b0, ttl});
    endfunction

    // translate one header and update the shadow table
    function automatic t_out translate(t_in x);
        t_out r;
        bit icmp, ok, tcp, udp;
        int hit;
        logic [15:0] kdp, key, mp, cp;
        logic [31:0] cip;
        r = passthru(x, ActPass);
        hit = -1;
        tcp = (x.protocol == ProtoTcp);
        udp = (x.protocol == ProtoUdp);
        icmp = (x.protocol == ProtoIcmp);
        ok = tcp || udp;
        if (cfg_en && x.operation == OpOut) begin
            if (icmp && x.icmp_type == IcmpEchoReq) ok = 1'b1;
            if (ok && (x.dst_ip & cfg_mask) == (cfg_masq & cfg_mask) && x.dst_ip != cfg_masq) begin
                kdp = icmp ? 16'd0 : x.dst_port;
                for (int i = 0; i < NumEntries; i++)
                    if (hit < 0 && tv[i] && tproto[i] == x.protocol && tcip[i] == x.src_ip &&
                        tpip[i] == x.dst_ip && tcport[i] == x.src_port && tpport[i] == kdp)
                        hit = i;
                if (hit < 0) begin
                    for (int i = 0; i < NumEntries; i++)
                        if (hit < 0 && (!tv[i] || aged(i, x.now_ms))) hit = i;
                    if (hit >= 0) begin
                        tv[hit] = 1'b1;
                        tproto[hit] = x.protocol;
                        tcip[hit] = x.src_ip;
                        tpip[hit] = x.dst_ip;
                        tcport[hit] = x.src_port;
                        tpport[hit] = kdp;
                        tmport[hit] = port_pool;
                        port_pool = (port_pool == 16'hFFFF) ? PortBase : port_pool + 16'd1;
                    end
                end
                if (hit < 0) begin
                    r.action = ActFull;
                end else begin
                    mp = tmport[hit];
                    tlast[hit] = x.now_ms;
                    r.action = ActRewrite;
                    r.out_src_ip = cfg_masq;
                    r.out_src_port = mp;
                    r.out_ip_checksum = fold32(x.ip_checksum, x.src_ip, cfg_masq);
                    if (icmp) begin
                        r.out_l4_checksum = fold16(x.l4_checksum, x.src_port, mp);
                    end else if (tcp || x.l4_checksum != 16'd0) begin
                        r.out_l4_checksum = fold16(fold32(x.l4_checksum, x.src_ip, cfg_masq),
                                                   x.src_port, mp);
                        if (udp && r.out_l4_checksum == 16'd0) r.out_l4_checksum = 16'hFFFF;
                    end
                end
            end
        end else if (cfg_en) begin
            if (icmp && x.icmp_type == IcmpEchoRep) ok = 1'b1;
            if (ok && x.dst_ip == cfg_masq) begin
                key = icmp ? x.src_port : x.dst_port;
                for (int i = 0; i < NumEntries; i++)
                    if (hit < 0 && tv[i] && tproto[i] == x.protocol && tmport[i] == key &&
                        tpip[i] == x.src_ip)
                        hit = i;
                if (hit >= 0) begin
                    cip = tcip[hit];
                    cp = tcport[hit];
                    tlast[hit] = x.now_ms;
                    r.action = ActRewrite;
                    r.out_dst_ip = cip;
                    r.out_ip_checksum = fold32(x.ip_checksum, x.dst_ip, cip);
                    if (icmp) begin
                        r.out_src_port = cp;
                        r.out_l4_checksum = fold16(x.l4_checksum, x.src_port, cp);
                    end else begin
                        r.out_dst_port = cp;
                        if (tcp || x.l4_checksum != 16'd0) begin
                            r.out_l4_checksum = fold16(fold32(x.l4_checksum, x.dst_ip, cip),
                                                       x.dst_port, cp);
                            if (udp && r.out_l4_checksum == 16'd0) r.out_l4_checksum = 16'hFFFF;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // result checking and prediction, both on the rising edge
    always @(posedge i_clk) begin : scoreboard
        t_out w;
        t_out p;
        if (o_out_valid && i_out_ready) begin
            if (rewrite_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", o_out.out_src_ip, '0);
            end else begin
                w = rewrite_q.pop_front();
                if (o_out.action != w.action)
                    report_mismatch("action", 32'(o_out.action), 32'(w.action));
                if (o_out.out_src_ip != w.out_src_ip)
                    report_mismatch("out_src_ip", o_out.out_src_ip, w.out_src_ip);
                if (o_out.out_dst_ip != w.out_dst_ip)
                    report_mismatch("out_dst_ip", o_out.out_dst_ip, w.out_dst_ip);
                if (o_out.out_src_port != w.out_src_port)
                    report_mismatch("out_src_port", 32'(o_out.out_src_port),
                                    32'(w.out_src_port));
                if (o_out.out_dst_port != w.out_dst_port)
                    report_mismatch("out_dst_port", 32'(o_out.out_dst_port),
                                    32'(w.out_dst_port));
                if (o_out.out_ip_checksum != w.out_ip_checksum)
                    report_mismatch("out_ip_checksum", 32'(o_out.out_ip_checksum),
                                    32'(w.out_ip_checksum));
                if (o_out.out_l4_checksum != w.out_l4_checksum)
                    report_mismatch("out_l4_checksum", 32'(o_out.out_l4_checksum),
                                    32'(w.out_l4_checksum));
                case (w.action)
                    ActRewrite: n_rewrite++;
                    ActFull:    n_full++;
                    default:    n_pass++;
                endcase
            end
        end
        if (i_in_valid && o_in_ready) begin
            p = translate(i_in);
            rewrite_q.push_back(cur_typed ? cur_want : p);
            n_items++;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            i_out_ready = 1'b0;
            hold_cnt--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin
        #20_000_000;
        $display("napt_header_rewriter: mismatch");
        $finish;
    end

    function automatic t_in mk(logic op, logic [7:0] proto, logic [7:0] itype,
                               logic [31:0] sip, logic [31:0] dip, logic [15:0] sport,
                               logic [15:0] dport, logic [15:0] ipc, logic [15:0] l4c,
                               logic [31:0] now);
        t_in x;
        x.operation = op; x.protocol = proto; x.icmp_type = itype;
        x.src_ip = sip; x.dst_ip = dip; x.src_port = sport; x.dst_port = dport;
        x.ip_checksum = ipc; x.l4_checksum = l4c; x.now_ms = now;
        return x;
    endfunction

    function automatic logic [7:0] pick_proto();
        int r;
        r = $urandom_range(99);
        return (r < 40) ? ProtoTcp : (r < 75) ? ProtoUdp : ProtoIcmp;
    endfunction

    // one random header: mostly well-formed flows and their replies, some noise
    function automatic t_in gen_item();
        t_in x;
        int r;
        int i;
        r = $urandom_range(99);
        if (r < 3) now_t = $urandom;
        else if (r < 6) now_t = now_t - $urandom_range(1000);
        else now_t = now_t + $urandom_range(tstep);
        r = $urandom_range(99);
        x = mk(OpOut, pick_proto(), IcmpEchoReq, clients[$urandom_range(3)],
               peers[$urandom_range(3)], cports[$urandom_range(3)],
               16'(80 + $urandom_range(3)), 16'($urandom), 16'($urandom), now_t);
        if ($urandom_range(99) < 15) x.l4_checksum = '0;
        if (r < 10) begin
            x = mk(1'($urandom_range(1)), 8'($urandom), 8'($urandom), $urandom, $urandom,
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        end else if (r < 65) begin
            if ($urandom_range(99) < 5) x.icmp_type = 8'($urandom);
        end else if (r < 90) begin
            i = $urandom_range(NumEntries - 1);
            x.operation = OpIn;
            x.dst_ip = cfg_masq;
            if (tv[i]) begin
                x.protocol = tproto[i];
                x.src_ip = tpip[i];
                x.icmp_type = IcmpEchoRep;
                if (tproto[i] == ProtoIcmp) x.src_port = tmport[i];
                else begin
                    x.src_port = tpport[i];
                    x.dst_port = tmport[i];
                end
                if ($urandom_range(99) < 10) x.dst_port[$urandom_range(15)] ^= 1'b1;
            end else begin
                x.icmp_type = IcmpEchoRep;
                x.dst_port = 16'(PortBase + $urandom_range(40));
            end
        end else begin
            case ($urandom_range(2))
                0: x.dst_ip = cfg_masq;
                1: x.dst_ip = ~(cfg_masq & cfg_mask) & cfg_mask | $urandom & ~cfg_mask;
                default: x.protocol = 8'($urandom);
            endcase
        end
        return x;
    endfunction

    task automatic send(t_in x, bit typed, t_out want);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = x;
        cur_typed = typed;
        cur_want = want;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        @(negedge i_clk);
    endtask

    // drain everything in flight before touching registers
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (rewrite_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CfgNatEnable: cfg_en = data[0];
            CfgMasqIp:    cfg_masq = data;
            CfgNetmask:   cfg_mask = data;
            CfgTcpTo:     cfg_tcp_to = data[30:0];
            CfgUdpTo:     cfg_udp_to = data[30:0];
            CfgIcmpTo:    cfg_icmp_to = data[30:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic setup(logic en, logic [31:0] masq, logic [31:0] mask,
                         logic [31:0] tcp_to, logic [31:0] udp_to, logic [31:0] icmp_to);
        wait_idle();
        write_reg(CfgNatEnable, {31'd0, en});
        write_reg(CfgMasqIp, masq);
        write_reg(CfgNetmask, mask);
        write_reg(CfgTcpTo, tcp_to);
        write_reg(CfgUdpTo, udp_to);
        write_reg(CfgIcmpTo, icmp_to);
        for (int k = 0; k < 4; k++) begin
            clients[k] = $urandom;
            peers[k] = (masq & mask) | ($urandom & ~mask);
            cports[k] = 16'($urandom);
        end
    endtask

    task automatic run_phase(int n, int sidle, int rstall, int step);
        send_idle = sidle;
        recv_stall = rstall;
        tstep = step;
        for (int k = 0; k < n; k++) send(gen_item(), 1'b0, '0);
    endtask

    task automatic add_item(t_in x, bit typed, t_out want);
        t_row r;
        r.kind = RowItem; r.idx = '0; r.data = '0;
        r.pkt = x; r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] data);
        t_row r;
        r.kind = RowCfg; r.idx = idx; r.data = data;
        r.pkt = '0; r.typed = 1'b0; r.want = '0;
        rows.push_back(r);
    endtask

    // l4 checksum that makes a UDP rewrite land on zero
    function automatic logic [15:0] zero_l4(logic [31:0] sip, logic [15:0] sport,
                                            logic [15:0] mp);
        for (int v = 0; v < 65536; v++)
            if (fold16(fold32(v[15:0], sip, MasqA), sport, mp) == 16'd0) return v[15:0];
        return '0;
    endfunction

    initial begin : stimulus
        t_in x;
        logic [31:0] cl;
        logic [31:0] pe;
        cl = 32'h0A00_0005;
        pe = 32'hC0A8_040A;

        // directed table
        x = mk(OpOut, ProtoTcp, 8'h00, '0, '0, '0, '0, '0, '0, '0);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpIn, 8'hFF, 8'hFF, '1, '1, '1, '1, '1, '1, '1);
        add_item(x, 1'b1, passthru(x, ActPass));
        add_cfg(CfgMasqIp, MasqA);
        add_cfg(CfgNetmask, MaskA);
        add_cfg(CfgNatEnable, 32'd1);
        add_item(mk(OpOut, ProtoTcp, 8'h00, cl, pe, 16'd1234, 16'd80,
                    16'h1C46, 16'hB1E6, 32'd1000), 1'b0, '0);
        add_item(mk(OpOut, ProtoTcp, 8'h00, cl, pe, 16'd1234, 16'd80,
                    16'h0000, 16'h0000, 32'd1010), 1'b0, '0);
        add_item(mk(OpIn, ProtoTcp, 8'h00, pe, MasqA, 16'd80, PortBase,
                    16'hFFFF, 16'hFFFF, 32'd1020), 1'b0, '0);
        // UDP: zero checksum kept, then one that computes to zero
        add_item(mk(OpOut, ProtoUdp, 8'h00, cl, pe, 16'd5353, 16'd53,
                    16'h4321, 16'h0000, 32'd1030), 1'b0, '0);
        add_item(mk(OpOut, ProtoUdp, 8'h00, cl, pe, 16'd5353, 16'd53,
                    16'h4321, zero_l4(cl, 16'd5353, PortBase + 16'd1), 32'd1040), 1'b0, '0);
        add_item(mk(OpIn, ProtoUdp, 8'h00, pe, MasqA, 16'd53, PortBase + 16'd1,
                    16'h2222, 16'h0000, 32'd1050), 1'b0, '0);
        // echo request out, reply in keyed on the id
        add_item(mk(OpOut, ProtoIcmp, IcmpEchoReq, cl, pe, 16'h1111, 16'hABCD,
                    16'h5555, 16'hAAAA, 32'd1060), 1'b0, '0);
        add_item(mk(OpIn, ProtoIcmp, IcmpEchoRep, pe, MasqA, PortBase + 16'd2, 16'h7777,
                    16'h5555, 16'hAAAA, 32'd1070), 1'b0, '0);
        x = mk(OpOut, ProtoIcmp, 8'd3, cl, pe, 16'h1111, 16'h0, 16'h1, 16'h2, 32'd1080);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpOut, 8'd2, 8'h00, cl, pe, 16'd1, 16'd2, 16'h3, 16'h4, 32'd1090);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpOut, ProtoTcp, 8'h00, cl, MasqA, 16'd1, 16'd2, 16'h3, 16'h4, 32'd1100);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpOut, ProtoTcp, 8'h00, cl, 32'h0808_0808, 16'd1, 16'd2, 16'h3, 16'h4, 32'd1110);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpIn, ProtoTcp, 8'h00, pe, MasqA, 16'd80, 16'd1, 16'h3, 16'h4, 32'd1120);
        add_item(x, 1'b1, passthru(x, ActPass));
        x = mk(OpIn, ProtoIcmp, IcmpEchoReq, pe, MasqA, PortBase + 16'd2, 16'd0,
               16'h3, 16'h4, 32'd1130);
        add_item(x, 1'b1, passthru(x, ActPass));
        add_item(mk(OpOut, ProtoTcp, 8'hFF, '1, 32'hC0A8_04FF, '1, '1, '1, '1, '1), 1'b0, '0);
        add_item(mk(OpOut, ProtoUdp, 8'hFF, '1, 32'hC0A8_0400, '1, '1, '1, '1, '1), 1'b0, '0);

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == RowCfg) begin
                wait_idle();
                write_reg(rows[k].idx, rows[k].data);
            end else begin
                send(rows[k].pkt, rows[k].typed, rows[k].want);
            end
        end
        cur_typed = 1'b0;

        // random phases across register settings and idle patterns
        setup(1'b1, MasqA, MaskA, 32'd300000, 32'd60000, 32'd30000);
        run_phase(250, 0, 0, 100);
        setup(1'b1, MasqA, MaskA, 32'd20, 32'd30, 32'd10);
        run_phase(250, 65, 0, 8);
        setup(1'b1, 32'h0, 32'h0, 32'd1000, 32'd1000, 32'd1000);
        run_phase(250, 0, 65, 50);
        setup(1'b1, 32'hFFFF_FFFF, MaskA, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        hold_req = 1'b1;
        run_phase(250, 24, 24, 1000);
        setup(1'b1, 32'h0A00_0001, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        run_phase(80, 10, 10, 5);
        setup(1'b0, MasqA, MaskA, 32'd100, 32'd100, 32'd100);
        run_phase(80, 30, 30, 5);

        // zero timeouts: every entry expires at once, so each new flow takes a fresh port
        setup(1'b1, MasqA, MaskA, 32'd0, 32'd0, 32'd0);
        send_idle = 0;
        recv_stall = 0;
        for (int k = 0; k < 70; k++) begin
            now_t = now_t + 32'd1;
            send(mk(OpOut, ProtoTcp, 8'h00, clients[0], peers[0], 16'($urandom), 16'd443,
                    16'($urandom), 16'($urandom), now_t), 1'b0, '0);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (rewrite_q.size() != 0)
            report_mismatch("results never delivered", rewrite_q.size(), '0);
        $display("covered %0d headers: %0d rewritten, %0d table full, %0d unchanged",
                 n_items, n_rewrite, n_full, n_pass);
        $display("%0d register writes across several settings and stall patterns", n_cfg);
        if (errors == 0) begin
            $display("napt_header_rewriter: match");
        end else begin
            $display("napt_header_rewriter: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/napt_pkg.sv
design/napt_cell.sv
design/napt_header_rewriter.sv
bench/napt_header_rewriter_test.sv
